// ===== hw/rtl/box_filter_row_sum_macros.svh =====
// Assertion macros shared by the box filter row sum RTL.
`ifndef BOX_FILTER_ROW_SUM_MACROS_SVH
`define BOX_FILTER_ROW_SUM_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every edge out of reset.
`define BRS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("box_filter_row_sum: invariant violated");

// Trigger at one edge implies the consequence at the next edge.
`define BRS_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("box_filter_row_sum: sequence violated");

`else

`define BRS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define BRS_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

// ===== hw/rtl/brs_pkg.sv =====
// Shared types and constants for the box filter row sum.
`timescale 1ns / 1ps

package brs_pkg;

    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 16;
    localparam int CHAN_W   = 2;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] WINDOW_RESET  = 7'd3;
    localparam logic [CFG_W-1:0] CHANNEL_RESET = 7'd1;

    typedef struct packed {
        logic [SUM_W-1:0]  window_sum;
        logic [CHAN_W-1:0] channel_index;
        logic              last_of_row;
    } result_t;

endpackage

// ===== hw/rtl/brs_cell.sv =====
// One delay-line cell: on shift, loads a new sample or takes its upstream neighbor; else holds.
`timescale 1ns / 1ps

module brs_cell
(
    input  logic                          clk,
    input  logic                          shift,
    input  logic                          load_new,
    input  logic [brs_pkg::SAMPLE_W-1:0] new_sample,
    input  logic [brs_pkg::SAMPLE_W-1:0] upstream,
    output logic [brs_pkg::SAMPLE_W-1:0] q
);

    logic [brs_pkg::SAMPLE_W-1:0] q_reg;
    logic [brs_pkg::SAMPLE_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (shift)
        begin
            q_next = load_new ? new_sample : upstream;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/brs_out_buf.sv =====
// Output register with a skid stage, so input takes a word while one waits.
`timescale 1ns / 1ps

module brs_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  brs_pkg::result_t  push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output brs_pkg::result_t  out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    brs_pkg::result_t main_reg, main_next;
    brs_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // no push possible here: drain skid into main on pop
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_next = push;
            main_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ===== hw/rtl/box_filter_row_sum.sv =====
// Top level of the streaming horizontal box filter row sum.
//
//   port group          direction  payload
//   s_* (samples)       in         tdata = sample[7:0]; tlast = end_of_row
//   m_* (window sums)   out        tdata = window_sum[15:0]; tuser = channel_index[1:0];
//                                  tlast = last_of_row
//   cfg_* (registers)   in         cfg_index selects, cfg_data[6:0] written on cfg_we
//
// One sample word per clock while s_tready is high; once the window fills, each sum is registered onto m_*.
// The delay line is a chain of MAX_WINDOW*MAX_CHANNELS cells; new samples enter at
// cell window*channels-1 and leave from cell 0, so the oldest sample is always at hand.
// Reset clears sums and counters; delay cells hold no reset value and need no clearing.
// s_tready drops only when both the output register and its skid stage hold words.
`timescale 1ns / 1ps
`include "box_filter_row_sum_macros.svh"

module box_filter_row_sum
#(
    parameter int MAX_WINDOW   = 64,
    parameter int MAX_CHANNELS = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [brs_pkg::SAMPLE_W-1:0]   s_tdata,   // [7:0] sample
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [brs_pkg::SUM_W-1:0]      m_tdata,   // [15:0] window_sum
    output logic [brs_pkg::CHAN_W-1:0]     m_tuser,   // [1:0] channel_index
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [brs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brs_pkg::CFG_W-1:0]      cfg_data
);

    localparam int DEPTH = MAX_WINDOW * MAX_CHANNELS;
    localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int CCW   = $clog2(MAX_CHANNELS + 1);
    localparam int CPW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PW    = WW + CCW;
    localparam logic [WW-1:0]  WIDTH_RESET_EFF =
        WW'((MAX_WINDOW < 3) ? MAX_WINDOW : 3);
    localparam logic [CCW-1:0] CHAN_RESET_EFF  = CCW'(1);
    localparam logic [DW-1:0]  LEN_RESET_M1    =
        DW'(((MAX_WINDOW < 3) ? MAX_WINDOW : 3) - 1);

    // configuration
    logic [brs_pkg::CFG_W-1:0] window_reg, window_next;
    logic [2:0]                chans_reg, chans_next;
    logic [WW-1:0]             eff_w_reg, eff_w_next;
    logic [CCW-1:0]            eff_c_reg, eff_c_next;
    logic [DW-1:0]             len_m1_reg, len_m1_next;
    logic [PW-1:0]             len_prod;

    // row state
    logic [CPW-1:0]            chan_pos_reg, chan_pos_next;
    logic [WW-1:0]             pixels_reg, pixels_next;
    logic [brs_pkg::SUM_W-1:0] sums_reg [MAX_CHANNELS];
    logic [brs_pkg::SUM_W-1:0] sum_new;
    logic [brs_pkg::SUM_W-1:0] sum_sub;

    logic                      accept;
    logic                      full_window;
    logic                      emit;
    logic                      pixel_done;
    logic                      cfg_known;
    logic                      row_clear;
    logic                      can_push;
    brs_pkg::result_t          result;
    brs_pkg::result_t          out_word;

    logic [brs_pkg::SAMPLE_W-1:0] cell_q [DEPTH];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = can_push;

    // ---------------- configuration ----------------
    always_comb
    begin
        window_next = window_reg;
        chans_next  = chans_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                brs_pkg::REG_WINDOW_WIDTH:  window_next = cfg_data;
                brs_pkg::REG_CHANNEL_COUNT: chans_next  = cfg_data[2:0];
                default: ;
            endcase
        end

        if (window_next == '0)
            eff_w_next = WW'(1);
        else if (32'(window_next) > 32'(MAX_WINDOW))
            eff_w_next = WW'(MAX_WINDOW);
        else
            eff_w_next = WW'(window_next);

        if (chans_next == '0)
            eff_c_next = CCW'(1);
        else if (32'(chans_next) > 32'(MAX_CHANNELS))
            eff_c_next = CCW'(MAX_CHANNELS);
        else
            eff_c_next = CCW'(chans_next);

        len_prod    = PW'(eff_w_next) * PW'(eff_c_next);
        len_m1_next = DW'(len_prod - PW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= brs_pkg::WINDOW_RESET;
            chans_reg  <= brs_pkg::CHANNEL_RESET[2:0];
            eff_w_reg  <= WIDTH_RESET_EFF;
            eff_c_reg  <= CHAN_RESET_EFF;
            len_m1_reg <= LEN_RESET_M1;
        end
        else
        begin
            window_reg <= window_next;
            chans_reg  <= chans_next;
            eff_w_reg  <= eff_w_next;
            eff_c_reg  <= eff_c_next;
            len_m1_reg <= len_m1_next;
        end
    end

    // ---------------- delay chain ----------------
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            brs_cell u_cell
            (
                .clk        (clk),
                .shift      (accept),
                .load_new   ((len_m1_reg == DW'(k)) || (k == DEPTH - 1)),
                .new_sample (s_tdata),
                .upstream   (cell_q[(k == DEPTH - 1) ? k : k + 1]),
                .q          (cell_q[k])
            );
        end
    endgenerate

    // ---------------- running sums ----------------
    assign full_window = 32'(pixels_reg) >= 32'(eff_w_reg);
    assign emit        = accept && (32'(pixels_reg) + 32'd1 >= 32'(eff_w_reg));
    assign pixel_done  = 32'(chan_pos_reg) + 32'd1 >= 32'(eff_c_reg);
    // a write to an unknown index leaves the row alone
    assign cfg_known   = (cfg_index == brs_pkg::REG_WINDOW_WIDTH) ||
                         (cfg_index == brs_pkg::REG_CHANNEL_COUNT);
    assign row_clear   = (cfg_we && cfg_known) || (accept && s_tlast);

    // drop the sample leaving the window, add the new one
    assign sum_sub = full_window ? brs_pkg::SUM_W'(cell_q[0]) : '0;
    assign sum_new = sums_reg[chan_pos_reg] - sum_sub + brs_pkg::SUM_W'(s_tdata);

    always_comb
    begin
        chan_pos_next = chan_pos_reg;
        pixels_next   = pixels_reg;
        if (row_clear)
        begin
            chan_pos_next = '0;
            pixels_next   = '0;
        end
        else if (accept)
        begin
            if (pixel_done)
            begin
                chan_pos_next = '0;
                if (!full_window)
                    pixels_next = pixels_reg + WW'(1);
            end
            else
            begin
                chan_pos_next = chan_pos_reg + CPW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_pos_reg <= '0;
            pixels_reg   <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
                sums_reg[i] <= '0;
        end
        else
        begin
            chan_pos_reg <= chan_pos_next;
            pixels_reg   <= pixels_next;
            if (row_clear)
            begin
                for (int i = 0; i < MAX_CHANNELS; i++)
                    sums_reg[i] <= '0;
            end
            else if (accept)
            begin
                sums_reg[chan_pos_reg] <= sum_new;
            end
        end
    end

    // ---------------- output ----------------
    always_comb
    begin
        result.window_sum    = sum_new;
        result.channel_index = brs_pkg::CHAN_W'(chan_pos_reg);
        result.last_of_row   = s_tlast;
    end

    brs_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = out_word.window_sum;
    assign m_tuser = out_word.channel_index;
    assign m_tlast = out_word.last_of_row;

    // ---------------- checks ----------------
    `BRS_ASSERT_ALWAYS(a_pixels_sat, clk, rst_n, pixels_reg <= eff_w_reg)
    `BRS_ASSERT_ALWAYS(a_chan_range, clk, rst_n, 32'(chan_pos_reg) < 32'(eff_c_reg))
    `BRS_ASSERT_NEXT(a_row_clear, clk, rst_n, accept && s_tlast,
        chan_pos_reg == '0 && pixels_reg == '0)
    `BRS_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, m_tvalid)
    `BRS_ASSERT_NEXT(a_len_match, clk, rst_n, 1'b1,
        32'(len_m1_reg) + 32'd1 == 32'(eff_w_reg) * 32'(eff_c_reg))

endmodule

// ===== dv/box_filter_row_sum_test.sv =====
// Self-checking stream testbench for box_filter_row_sum with a window-sum scoreboard.
`timescale 1ns / 1ps

localparam int MAX_WINDOW   = 64;
localparam int MAX_CHANNELS = 4;

localparam logic [brs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
localparam logic [brs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

class row_sum_tracker;
    bit [7:0]          delay_line [0:MAX_WINDOW*MAX_CHANNELS-1];
    bit [15:0]         sums [0:MAX_CHANNELS-1];
    int                chan_pos;
    int                pix_seen;
    int                wr_ptr;
    bit [6:0]          width_reg;
    bit [2:0]          chan_reg;
    brs_pkg::result_t  expected_sums [$];
    int                mismatches;

    function new();
        width_reg  = brs_pkg::WINDOW_RESET;
        chan_reg   = brs_pkg::CHANNEL_RESET[2:0];
        mismatches = 0;
        clear_row();
    endfunction

    function void clear_row();
        foreach (sums[i])
            sums[i] = '0;
        chan_pos = 0;
        pix_seen = 0;
        wr_ptr   = 0;
    endfunction

    function int width_eff();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WINDOW)
            return MAX_WINDOW;
        return width_reg;
    endfunction

    function int channels_eff();
        if (chan_reg == 0)
            return 1;
        if (chan_reg > MAX_CHANNELS)
            return MAX_CHANNELS;
        return chan_reg;
    endfunction

    function int pending();
        return expected_sums.size();
    endfunction

    function void write_register(logic [brs_pkg::CFG_IDX_W-1:0] idx,
                                 logic [brs_pkg::CFG_W-1:0] val);
        if (idx == brs_pkg::REG_WINDOW_WIDTH)
        begin
            width_reg = val;
            clear_row();
        end
        else if (idx == brs_pkg::REG_CHANNEL_COUNT)
        begin
            chan_reg = val[2:0];
            clear_row();
        end
    endfunction

    function void note_sample(logic [7:0] smp, logic eor);
        int               w;
        int               cn;
        int               c;
        int               wp;
        int               slot;
        brs_pkg::result_t r;
        w  = width_eff();
        cn = channels_eff();
        if (chan_pos >= cn)
            chan_pos = 0;
        if (wr_ptr >= w)
            wr_ptr = 0;
        c    = chan_pos;
        wp   = wr_ptr;
        slot = wp * MAX_CHANNELS + c;
        // Drop the oldest pixel of this channel once the window is full.
        if (pix_seen >= w)
            sums[c] = sums[c] - delay_line[slot];
        sums[c] = sums[c] + smp;
        delay_line[slot] = smp;
        if (pix_seen + 1 >= w)
        begin
            r.window_sum    = sums[c];
            r.channel_index = c[1:0];
            r.last_of_row   = eor;
            expected_sums.push_back(r);
        end
        if (c + 1 >= cn)
        begin
            chan_pos = 0;
            wr_ptr   = (wp + 1 >= w) ? 0 : wp + 1;
            if (pix_seen < w)
                pix_seen++;
        end
        else
            chan_pos = c + 1;
        if (eor)
            clear_row();
    endfunction

    function void report_mismatch(string what);
        mismatches++;
        // Cap the log; the count still covers every failure.
        if (mismatches <= 100)
            $display("%0t mismatch: %s", $time, what);
    endfunction

    function void check_sum(logic [15:0] sum, logic [1:0] ch, logic last);
        brs_pkg::result_t want;
        if (expected_sums.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word sum=%0d ch=%0d last=%b", sum, ch, last));
            return;
        end
        want = expected_sums.pop_front();
        if (sum !== want.window_sum)
            report_mismatch($sformatf("window_sum got %0d want %0d", sum, want.window_sum));
        if (ch !== want.channel_index)
            report_mismatch($sformatf("channel_index got %0d want %0d", ch,
                                      want.channel_index));
        if (last !== want.last_of_row)
            report_mismatch($sformatf("last_of_row got %b want %b", last, want.last_of_row));
    endfunction
endclass

module box_filter_row_sum_test;

    localparam int ITEM_TARGET  = 1500;
    localparam int CALM_AFTER   = 1250;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 100;
    localparam int CYCLE_LIMIT  = 400000;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [brs_pkg::SAMPLE_W-1:0]  s_tdata;   // [7:0] sample
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [brs_pkg::SUM_W-1:0]     m_tdata;   // [15:0] window_sum
    logic [brs_pkg::CHAN_W-1:0]    m_tuser;   // [1:0] channel_index
    logic                          m_tlast;
    logic                          cfg_we;
    logic [brs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [brs_pkg::CFG_W-1:0]     cfg_data;

    row_sum_tracker sb;
    int             sent_count;
    int             cycle_count;
    bit             calm;
    bit             hold_request;

    box_filter_row_sum
    #(
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_CHANNELS (MAX_CHANNELS)
    )
    uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sample both handshakes and register writes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_sum(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata, s_tlast);
            if (cfg_we)
                sb.write_register(cfg_index, cfg_data);
        end
    end

    // Receiver side: random stalls, one long hold on request, none at the end.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (calm)
            begin
                @(negedge clk);
                m_tready = 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                @(negedge clk);
                m_tready = 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic send_sample(input logic [7:0] smp, input logic eor);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tlast  = eor;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        if (sent_count >= CALM_AFTER)
            calm = 1'b1;
    endtask

    task automatic idle_input(input int n);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold the input until every expected word is out, then let the pipe settle.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [brs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brs_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_row(input int total, input bit with_eor, input int gap_odds);
        for (int i = 0; i < total; i++)
        begin
            if (gap_odds > 0 && !calm && $urandom_range(1, gap_odds) == 1)
                idle_input($urandom_range(1, 10));
            send_sample(8'($urandom_range(0, 255)), with_eor && (i == total - 1));
        end
    endtask

    initial
    begin
        int         w;
        int         cn;
        int         rows;
        int         total;
        int         gap_odds;
        int         phase;
        logic [6:0] wv;
        logic [6:0] cv;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sent_count   = 0;
        cycle_count  = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        sb           = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: a row shorter than the window, then a full one.
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b1);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b1);
        wait_drained();

        write_reg(brs_pkg::REG_WINDOW_WIDTH, 7'd1);
        write_reg(brs_pkg::REG_CHANNEL_COUNT, 7'd1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b1);
        wait_drained();

        // Zero width and zero channels both act as one.
        write_reg(brs_pkg::REG_WINDOW_WIDTH, 7'd0);
        write_reg(brs_pkg::REG_CHANNEL_COUNT, 7'd0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd128, 1'b1);
        wait_drained();

        // Channel count saturates; end the row in the middle of a pixel.
        write_reg(brs_pkg::REG_WINDOW_WIDTH, 7'd2);
        write_reg(brs_pkg::REG_CHANNEL_COUNT, 7'd7);
        send_sample(8'd255, 1'b0);
        send_sample(8'd1, 1'b0);
        send_sample(8'd2, 1'b0);
        send_sample(8'd3, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd254, 1'b0);
        send_sample(8'd253, 1'b0);
        send_sample(8'd252, 1'b0);
        send_sample(8'd0, 1'b1);
        wait_drained();

        // Unknown index must not disturb the row.
        send_sample(8'd170, 1'b0);
        wait_drained();
        write_reg(REG_SPARE_B, 7'h7F);
        send_sample(8'd85, 1'b0);
        send_sample(8'd15, 1'b0);
        send_sample(8'd240, 1'b0);
        send_sample(8'd99, 1'b1);

        phase = 0;
        while (sent_count < ITEM_TARGET)
        begin
            wait_drained();
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0:       wv = 7'd0;
                        1:       wv = 7'd1;
                        2:       wv = 7'd64;
                        default: wv = 7'd127;
                    endcase
                end
                1:       wv = 7'($urandom_range(9, 64));
                2:       wv = 7'($urandom_range(65, 127));
                default: wv = 7'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 5))
                0:       cv = $urandom_range(0, 1) ? 7'd0 : 7'd7;
                1:       cv = 7'($urandom_range(0, 127));
                default: cv = 7'($urandom_range(1, 4));
            endcase
            // Saturating width first, then a phase that can fill the output.
            if (phase == 0)
            begin
                wv = 7'd100;
                cv = 7'd1;
            end
            else if (phase == 1)
            begin
                wv = 7'd1;
                cv = 7'd1;
            end
            write_reg(brs_pkg::REG_WINDOW_WIDTH, wv);
            write_reg(brs_pkg::REG_CHANNEL_COUNT, cv);
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          7'($urandom_range(0, 127)));
            w  = sb.width_eff();
            cn = sb.channels_eff();
            if (phase == 1)
            begin
                hold_request = 1'b1;
                send_row(60, 1'b1, 0);
            end
            else
            begin
                rows = $urandom_range(1, 3);
                repeat (rows)
                begin
                    gap_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 8);
                    if ($urandom_range(0, 5) == 0)
                    begin
                        // Broken row: cut short or left without its end marker.
                        total = $urandom_range(1, (w + 2) * cn);
                        send_row(total, $urandom_range(0, 3) != 0, gap_odds);
                    end
                    else
                        send_row((w + $urandom_range(0, 12)) * cn, 1'b1, gap_odds);
                end
            end
            phase++;
        end

        wait_drained();
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
